// ===== design/pfpa_pkg.sv =====
// ---------------------------------------------------------------------------
// Per-CPU free page allocator package
// Shared codes, and the command and status bundles between the controller
// and the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfpa_pkg;

  // Request kinds.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_OOM        = 2'd1;
  localparam logic [1:0] ST_MISALIGNED = 2'd2;
  localparam logic [1:0] ST_OUTSIDE    = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_REGION_BASE  = 1'b0;
  localparam logic CFG_REGION_PAGES = 1'b1;

  // Configuration reset values.
  localparam logic [47:0] REGION_BASE_RESET  = 48'h0000_0010_0000;
  localparam logic [12:0] REGION_PAGES_RESET = 13'd4096;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;    // capture the accepted request beat
    logic exec;    // decide, check and update the pools
    logic finish;  // take the link memory read and close an allocation
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need_read;  // allocation hit a pool; link memory read is in flight
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/pfpa_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfpa_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/pfpa_ctrl.sv =====
// ---------------------------------------------------------------------------
// Allocator controller
// Sequences one request at a time through execute and, for an allocation
// that hits a pool, a finish step that waits on the link memory read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfpa_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output      logic                  busy,
  input  wire pfpa_pkg::dp_status_t  status,
  output      pfpa_pkg::ctrl_cmd_t   cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = status.need_read ? S_FINISH : S_IDLE;
      end
      S_FINISH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commands to the datapath.
  assign busy       = (state != S_IDLE);
  assign cmd.load   = (state == S_IDLE) && start;
  assign cmd.exec   = (state == S_EXEC);
  assign cmd.finish = (state == S_FINISH);

endmodule

`default_nettype wire

// ===== design/pfpa_dp.sv =====
// ---------------------------------------------------------------------------
// Allocator datapath
// Holds the configuration, the per-pool heads and counts, the link memory
// and the result registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfpa_dp #(
  parameter int CPU_COUNT   = 4,
  parameter int PAGE_FRAMES = 4096,
  parameter int PAGE_SHIFT  = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire pfpa_pkg::ctrl_cmd_t   cmd,
  output      pfpa_pkg::dp_status_t  status,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [47:0]           cfg_data,
  input  wire logic                  req_type,
  input  wire logic [1:0]            cpu_id,
  input  wire logic [47:0]           page_addr,
  output      logic                  done,
  output      logic [1:0]            res_status,
  output      logic [47:0]           res_addr,
  output      logic [1:0]            res_pool,
  output      logic [12:0]           res_count
);

  localparam int PW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int FW = $clog2(PAGE_FRAMES);
  localparam int CW = $clog2(PAGE_FRAMES + 1);
  localparam int UW = (CW > 13) ? CW : 13;
  localparam int OW = 48 - PAGE_SHIFT;

  // Requester pool: cpu_id folded into the pool range.
  function automatic logic [PW-1:0] fold_cpu(input logic [1:0] id);
    logic [4:0] v;
    v = {3'b000, id};
    for (int k = 0; k < 3; k++) begin
      if (v >= 5'(CPU_COUNT)) begin
        v = v - 5'(CPU_COUNT);
      end
    end
    return PW'(v);
  endfunction

  // Configuration registers.
  logic [47:0] region_base;
  logic [12:0] region_pages;

  // Pool state.
  logic [FW-1:0] heads  [CPU_COUNT];
  logic [CW-1:0] counts [CPU_COUNT];

  // Captured request.
  logic          req_q;
  logic [PW-1:0] own_q;
  logic [47:0]   addr_q;

  // Allocation carried into the finish step.
  logic [PW-1:0] sel_pool;
  logic [FW-1:0] sel_frame;
  logic [CW-1:0] sel_count;

  // Link memory ports.
  logic          ram_we;
  logic [FW-1:0] ram_waddr;
  logic [FW-1:0] ram_wdata;
  logic [FW-1:0] ram_raddr;
  logic [FW-1:0] ram_rdata;

  // Execute-step decode.
  logic [CPU_COUNT-1:0] nonempty;
  logic                 hit;
  logic [PW-1:0]        pick;
  logic [PW-1:0]        pool_idx;
  logic [FW-1:0]        cur_head;
  logic [CW-1:0]        cur_count;
  logic [CW-1:0]        inc_count;
  logic [47:0]          base_al;
  logic [48:0]          diff;
  logic [OW-1:0]        frame_off;
  logic [UW-1:0]        usable;
  logic                 misaligned;
  logic                 outside;
  logic [FW-1:0]        free_frame;
  logic                 alloc_hit;
  logic                 free_ok;

  // Round-robin search over nonempty pools, starting at the requester.
  always_comb begin
    logic [PW:0] p;
    for (int i = 0; i < CPU_COUNT; i++) begin
      nonempty[i] = (counts[i] != '0);
    end
    hit  = 1'b0;
    pick = own_q;
    for (int i = 0; i < CPU_COUNT; i++) begin
      p = {1'b0, own_q} + (PW + 1)'(i);
      if (p >= (PW + 1)'(CPU_COUNT)) begin
        p = p - (PW + 1)'(CPU_COUNT);
      end
      if (!hit && nonempty[p[PW-1:0]]) begin
        hit  = 1'b1;
        pick = p[PW-1:0];
      end
    end
  end

  // Pool selection and address checks.
  always_comb begin
    alloc_hit  = (req_q == pfpa_pkg::REQ_ALLOC) && hit;
    pool_idx   = alloc_hit ? pick : own_q;
    cur_head   = heads[pool_idx];
    cur_count  = counts[pool_idx];
    inc_count  = (cur_count < CW'(PAGE_FRAMES)) ? cur_count + CW'(1) : cur_count;
    base_al    = {region_base[47:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    diff       = {1'b0, addr_q} - {1'b0, base_al};
    frame_off  = diff[47:PAGE_SHIFT];
    usable     = (UW'(region_pages) > UW'(PAGE_FRAMES)) ?
                 UW'(PAGE_FRAMES) : UW'(region_pages);
    misaligned = |addr_q[PAGE_SHIFT-1:0];
    outside    = diff[48] || (frame_off >= OW'(usable));
    free_frame = frame_off[FW-1:0];
    free_ok    = (req_q == pfpa_pkg::REQ_FREE) && !misaligned && !outside;
    status.need_read = cmd.exec && alloc_hit;
  end

  // Link memory access: push writes, pop reads the head's successor.
  assign ram_we    = cmd.exec && free_ok;
  assign ram_waddr = free_frame;
  assign ram_wdata = cur_head;
  assign ram_raddr = cur_head;

  pfpa_ram #(
    .WIDTH (FW),
    .DEPTH (PAGE_FRAMES)
  ) u_link (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base  <= pfpa_pkg::REGION_BASE_RESET;
      region_pages <= pfpa_pkg::REGION_PAGES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pfpa_pkg::CFG_REGION_BASE:  region_base  <= cfg_data;
        pfpa_pkg::CFG_REGION_PAGES: region_pages <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q  <= req_type;
      own_q  <= fold_cpu(cpu_id);
      addr_q <= page_addr;
    end
  end

  // Pool heads and counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CPU_COUNT; i++) begin
        heads[i]  <= '0;
        counts[i] <= '0;
      end
    end else if (cmd.exec) begin
      if (alloc_hit) begin
        counts[pool_idx] <= cur_count - CW'(1);
      end else if (free_ok) begin
        heads[pool_idx]  <= free_frame;
        counts[pool_idx] <= inc_count;
      end
    end else if (cmd.finish) begin
      heads[sel_pool] <= ram_rdata;
    end
  end

  // Allocation details held for the finish step.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      sel_pool  <= pool_idx;
      sel_frame <= cur_head;
      sel_count <= cur_count - CW'(1);
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.exec && !alloc_hit) || cmd.finish;
    end
  end

  // Result beat registers.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_status <= pfpa_pkg::ST_OK;
      res_addr   <= base_al + (48'(sel_frame) << PAGE_SHIFT);
      res_pool   <= 2'(sel_pool);
      res_count  <= 13'(sel_count);
    end else if (cmd.exec) begin
      res_addr <= '0;
      res_pool <= 2'(own_q);
      if (req_q == pfpa_pkg::REQ_ALLOC) begin
        res_status <= pfpa_pkg::ST_OOM;
        res_count  <= '0;
      end else if (misaligned) begin
        res_status <= pfpa_pkg::ST_MISALIGNED;
        res_count  <= 13'(cur_count);
      end else if (outside) begin
        res_status <= pfpa_pkg::ST_OUTSIDE;
        res_count  <= 13'(cur_count);
      end else begin
        res_status <= pfpa_pkg::ST_OK;
        res_count  <= 13'(inc_count);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/percpu_free_page_allocator_core.sv =====
// A free, a rejected free or an out-of-memory allocate gives its result beat after the
// execute step; an allocate served from a pool adds a finish step for the registered read
// of the link memory that yields the pool's new head. A new request is taken only when
// the controller is idle, and busy covers the work.
// Reset clears all pool counts and loads the default region; the link memory is not cleared.
// Result beats are strobed on done for one cycle and cannot be held off.
// ---------------------------------------------------------------------------
// Per-CPU free page allocator core
// Per-CPU LIFO free-page lists chained through a next-link memory, with
// round-robin stealing from other pools when the requester's pool is empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module percpu_free_page_allocator_core #(
  parameter int CPU_COUNT   = 4,
  parameter int PAGE_FRAMES = 4096,
  parameter int PAGE_SHIFT  = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic        req_type,
  input  wire logic [1:0]  cpu_id,
  input  wire logic [47:0] page_addr,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [47:0] cfg_data,
  output      logic        done,
  output      logic [1:0]  status,
  output      logic [47:0] granted_addr,
  output      logic [1:0]  pool_used,
  output      logic [12:0] pool_free_count
);

  pfpa_pkg::ctrl_cmd_t  cmd;
  pfpa_pkg::dp_status_t dp_status;

  // Sequencer.
  pfpa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (dp_status),
    .cmd    (cmd)
  );

  // Pools, link memory and result registers.
  pfpa_dp #(
    .CPU_COUNT   (CPU_COUNT),
    .PAGE_FRAMES (PAGE_FRAMES),
    .PAGE_SHIFT  (PAGE_SHIFT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (dp_status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_type   (req_type),
    .cpu_id     (cpu_id),
    .page_addr  (page_addr),
    .done       (done),
    .res_status (status),
    .res_addr   (granted_addr),
    .res_pool   (pool_used),
    .res_count  (pool_free_count)
  );

endmodule

`default_nettype wire
